// ----- hdl/circular_angle_smoother_defines.svh -----
// assertion helpers, used by the sequencer (cas_ctrl)
`ifndef CIRCULAR_ANGLE_SMOOTHER_DEFINES_SVH
`define CIRCULAR_ANGLE_SMOOTHER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CAS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CAS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/cas_pkg.sv -----
`timescale 1ns / 1ps

package cas_pkg;

    localparam int ANGLE_W    = 16;
    localparam int WLEN_W     = 5;
    localparam int GAIN_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int ATAN_IW    = 5;
    localparam int ATAN_N     = 32;
    localparam int SIN_N      = 257;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd15;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd77;
    localparam logic [GAIN_W-1:0] GAIN_FULL  = 9'd256;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_GAIN = 2'd1;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef logic [63:0] div_tab_t  [41];
    typedef logic [15:0] sin_tab_t  [SIN_N];
    typedef logic [31:0] atan_tab_t [ATAN_N];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_PREP,
        ST_ROTATE,
        ST_SMOOTH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_issue;
        logic cordic_init;
        logic cordic_step;
        logic smooth;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic rd_last;
        logic cordic_last;
    } status_t;

    // series divisors: (2n)(2n+1) for sine, 2n+1 for arctangent
    function automatic div_tab_t build_taylor_div();
        div_tab_t tab;
        for (int n = 0; n < 41; n++) begin
            tab[n] = 64'(2 * n) * 64'(2 * n + 1);
        end
        return tab;
    endfunction

    function automatic div_tab_t build_odd_div();
        div_tab_t tab;
        for (int n = 0; n < 41; n++) begin
            tab[n] = 64'(2 * n + 1);
        end
        return tab;
    endfunction

    localparam div_tab_t TAYLOR_DIV = build_taylor_div();
    localparam div_tab_t ODD_DIV    = build_odd_div();

    // first quadrant of sine in q1.15, 1.0 saturated
    function automatic sin_tab_t build_sin_quarter();
        sin_tab_t    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      q;
        for (int k = 0; k < SIN_N; k++) begin
            x    = (64'(k) * PI_Q30) / 64'd512;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if ((n % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            q = (sum * 32768 + longint'(64'h2000_0000)) >>> 30;
            tab[k] = (q > 32767) ? 16'd32767 : 16'(q);
        end
        return tab;
    endfunction

    // atan(2^-i) in units of 2^-32 turn
    function automatic atan_tab_t build_atan();
        atan_tab_t   tab;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] p;
        longint      sum;
        for (int i = 0; i < ATAN_N; i++) begin
            if (i == 0) begin
                tab[i] = 32'h2000_0000;
            end else if (i > 30) begin
                tab[i] = '0;
            end else begin
                t   = 64'd1 << (30 - i);
                t2  = (t * t) >> 30;
                p   = t;
                sum = longint'(t);
                for (int n = 1; n <= 40; n++) begin
                    p = (p * t2) >> 30;
                    if ((n % 2) == 1) begin
                        sum = sum - longint'(p / ODD_DIV[n]);
                    end else begin
                        sum = sum + longint'(p / ODD_DIV[n]);
                    end
                end
                if (sum < 0) begin
                    sum = 0;
                end
                tab[i] = 32'((64'(sum) << 31) / PI_Q30);
            end
        end
        return tab;
    endfunction

    localparam sin_tab_t  SIN_QUARTER = build_sin_quarter();
    localparam atan_tab_t ATAN_TAB    = build_atan();

    // full-turn sine from the quarter table, 10-bit angle
    function automatic logic signed [15:0] sin_lookup(input logic [9:0] k);
        logic [8:0]  r;
        logic [8:0]  rm;
        logic [15:0] v;
        r  = {1'b0, k[7:0]};
        rm = 9'd256 - r;
        case (k[9:8])
            2'd0:    v = SIN_QUARTER[r];
            2'd1:    v = SIN_QUARTER[rm];
            2'd2:    v = -SIN_QUARTER[r];
            default: v = -SIN_QUARTER[rm];
        endcase
        return $signed(v);
    endfunction

endpackage

// ----- hdl/cas_ram.sv -----
`timescale 1ns / 1ps

module cas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/cas_ctrl.sv -----
`timescale 1ns / 1ps
`include "circular_angle_smoother_defines.svh"

module cas_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  cas_pkg::status_t status,
    output cas_pkg::cmd_t    cmd
);

    import cas_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                if (status.rd_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.cordic_init = 1'b1;
                state_next      = ST_ROTATE;
            end
            ST_ROTATE: begin
                cmd.cordic_step = 1'b1;
                if (status.cordic_last) begin
                    state_next = ST_SMOOTH;
                end
            end
            ST_SMOOTH: begin
                cmd.smooth = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    `CAS_ASSERT_IMP(a_no_overwrite, cmd.out_load, !m_valid_reg || m_ready, "result overwritten")
    `CAS_ASSERT_NXT(a_load_shows, cmd.out_load, m_valid_reg, "loaded result not valid")
    `CAS_ASSERT_NXT(a_rotate_done, state_reg == ST_ROTATE && status.cordic_last,
                    state_reg == ST_SMOOTH, "rotation did not end")
    `CAS_ASSERT_NXT(a_accept_reads, s_valid && s_ready, state_reg == ST_READ,
                    "item accepted without window read")

endmodule

// ----- hdl/cas_datapath.sv -----
`timescale 1ns / 1ps

module cas_datapath #(
    parameter int WINDOW_MAX   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cas_pkg::cmd_t                   cmd,
    output cas_pkg::status_t                status,
    input  logic                            cfg_wr_en,
    input  logic [cas_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cas_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [cas_pkg::ANGLE_W-1:0]     s_angle_in,
    output logic [cas_pkg::ANGLE_W-1:0]     m_smoothed_angle,
    output logic [cas_pkg::ANGLE_W-1:0]     m_window_mean
);

    import cas_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW_MAX);
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W  = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;
    localparam int SUM_W  = 17 + $clog2(WINDOW_MAX);
    localparam int XY_W   = SUM_W + 10;
    localparam int STEP_W = $clog2(CORDIC_STEPS);

    // configuration
    logic [WLEN_W-1:0] wlen_reg;
    logic [GAIN_W-1:0] gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= WLEN_RESET;
            gain_reg <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH:  wlen_reg <= cfg_wdata[WLEN_W-1:0];
                REG_SMOOTHING_GAIN: gain_reg <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ring addressing
    logic [IDX_W-1:0] widx_reg;
    logic [IDX_W-1:0] raddr_reg;
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] rd_cnt_reg;
    logic [ANGLE_W-1:0] ring_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            widx_reg   <= '0;
            fill_reg   <= '0;
            raddr_reg  <= '0;
            rd_cnt_reg <= '0;
        end else begin
            if (cmd.load) begin
                widx_reg   <= (widx_reg == IDX_W'(WINDOW_MAX - 1)) ? '0 : widx_reg + 1'b1;
                fill_reg   <= (fill_reg < LEN_W'(WINDOW_MAX)) ? fill_reg + 1'b1 : fill_reg;
                raddr_reg  <= widx_reg;
                rd_cnt_reg <= '0;
            end else if (cmd.rd_issue) begin
                raddr_reg  <= (raddr_reg == '0) ? IDX_W'(WINDOW_MAX - 1) : raddr_reg - 1'b1;
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
        end
    end

    cas_ram #(
        .WIDTH(ANGLE_W),
        .DEPTH(WINDOW_MAX)
    ) u_ring (
        .aclk (aclk),
        .we   (cmd.load),
        .waddr(widx_reg),
        .wdata(s_angle_in),
        .re   (cmd.rd_issue),
        .raddr(raddr_reg),
        .rdata(ring_rdata)
    );

    // entries averaged: fill count against the clamped window length
    logic [CMP_W-1:0] wlen_ext;
    logic [CMP_W-1:0] len_eff;
    logic [CMP_W-1:0] fill_ext;
    logic [LEN_W-1:0] n_items;

    always_comb begin
        wlen_ext = CMP_W'(wlen_reg);
        fill_ext = CMP_W'(fill_reg);
        if (wlen_ext == '0) begin
            len_eff = CMP_W'(1);
        end else if (wlen_ext > CMP_W'(WINDOW_MAX)) begin
            len_eff = CMP_W'(WINDOW_MAX);
        end else begin
            len_eff = wlen_ext;
        end
        n_items = (fill_ext < len_eff) ? fill_reg : LEN_W'(len_eff);
    end

    assign status.rd_last = (rd_cnt_reg == n_items - 1'b1);

    // cosine and sine sums
    logic              acc_en_reg;
    logic signed [SUM_W-1:0] sum_cos_reg;
    logic signed [SUM_W-1:0] sum_sin_reg;
    logic [9:0]        k_sin;
    logic [9:0]        k_cos;

    assign k_sin = ring_rdata[ANGLE_W-1:ANGLE_W-10];
    assign k_cos = k_sin + 10'd256;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg  <= 1'b0;
            sum_cos_reg <= '0;
            sum_sin_reg <= '0;
        end else begin
            acc_en_reg <= cmd.rd_issue;
            if (cmd.load) begin
                sum_cos_reg <= '0;
                sum_sin_reg <= '0;
            end else if (acc_en_reg) begin
                sum_cos_reg <= sum_cos_reg + SUM_W'(sin_lookup(k_cos));
                sum_sin_reg <= sum_sin_reg + SUM_W'(sin_lookup(k_sin));
            end
        end
    end

    // vectoring cordic, one iteration a cycle
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic [31:0]            z_reg;
    logic [STEP_W-1:0]      step_reg;
    logic signed [XY_W-1:0] x0;
    logic signed [XY_W-1:0] y0;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic [31:0]            atan_v;

    assign x0     = XY_W'(sum_cos_reg) <<< 8;
    assign y0     = XY_W'(sum_sin_reg) <<< 8;
    assign dx     = y_reg >>> step_reg;
    assign dy     = x_reg >>> step_reg;
    assign atan_v = ATAN_TAB[ATAN_IW'(step_reg)];

    assign status.cordic_last = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.cordic_init) begin
            step_reg <= '0;
            if (x0 < 0) begin
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= 32'h8000_0000;
            end else begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end else if (cmd.cordic_step) begin
            step_reg <= step_reg + 1'b1;
            if (y_reg >= 0) begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_v;
            end else begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_v;
            end
        end
    end

    // mean rounding and exponential smoothing
    logic [31:0]          z_rnd;
    logic [ANGLE_W-1:0]   mean_w;
    logic [GAIN_W-1:0]    gain_eff;
    logic [ANGLE_W-1:0]   diff16;
    logic signed [25:0]   prod;
    logic signed [25:0]   stepv;
    logic [ANGLE_W-1:0]   held_reg;
    logic [ANGLE_W-1:0]   mean_reg;
    logic                 first_reg;
    logic [ANGLE_W-1:0]   out_held_reg;
    logic [ANGLE_W-1:0]   out_mean_reg;

    assign z_rnd    = z_reg + 32'h0000_8000;
    assign mean_w   = (sum_cos_reg == '0 && sum_sin_reg == '0) ? '0 : z_rnd[31:16];
    assign gain_eff = (gain_reg > GAIN_FULL) ? GAIN_FULL : gain_reg;
    assign diff16   = mean_w - held_reg;
    assign prod     = 26'($signed(diff16)) * 26'($signed({1'b0, gain_eff}));
    assign stepv    = prod >>> 8;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            first_reg <= 1'b1;
        end else if (cmd.smooth) begin
            first_reg <= 1'b0;
            if (first_reg) begin
                held_reg <= mean_w;
            end else begin
                held_reg <= held_reg + stepv[ANGLE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.smooth) begin
            mean_reg <= mean_w;
        end
        if (cmd.out_load) begin
            out_held_reg <= held_reg;
            out_mean_reg <= mean_reg;
        end
    end

    assign m_smoothed_angle = out_held_reg;
    assign m_window_mean    = out_mean_reg;

endmodule

// ----- hdl/circular_angle_smoother.sv -----
`timescale 1ns / 1ps
// per item (n = angles averaged): accept, read n angles, one ring read each, drain, prepare,
// rotate with one cordic iteration per cycle, smooth, load the output register (held off
// while a result waits on m_ready); m_valid is registered from the load, and s_ready only
// returns after it. reset (aresetn low, synchronous): empty window, zero sums, first-result flag set,
// window_length 15, smoothing_gain 77; ring contents stay undefined until written

module circular_angle_smoother #(
    parameter int WINDOW_MAX   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cas_pkg::ANGLE_W-1:0]     s_angle_in,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cas_pkg::ANGLE_W-1:0]     m_smoothed_angle,
    output logic [cas_pkg::ANGLE_W-1:0]     m_window_mean,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [cas_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cas_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import cas_pkg::*;

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: accept, read window newest first, rotate, smooth, hand off result
    cas_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .status (status),
        .cmd    (cmd)
    );

    // datapath: angle ring, cos/sin sums, cordic, smoothing and output register
    // the output register lets the sequencer take the next item while a
    // result still waits on m_ready
    cas_datapath #(
        .WINDOW_MAX  (WINDOW_MAX),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_angle_in      (s_angle_in),
        .m_smoothed_angle(m_smoothed_angle),
        .m_window_mean   (m_window_mean)
    );

endmodule
